### hw/rtl/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// shared types and constants of the running mean and deviation block
// ----------------------------------------------------------------------------
package rmsd_pkg;

  localparam int ALU_W  = 66;
  localparam int STEP_W = 7;

  localparam logic [STEP_W-1:0] DIV_ADD_STEPS = 7'd48;
  localparam logic [STEP_W-1:0] DIV_RPT_STEPS = 7'd64;
  localparam logic [STEP_W-1:0] MUL_STEPS     = 7'd48;
  localparam logic [STEP_W-1:0] SQRT_STEPS    = 7'd32;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] res;
    logic             carry;
  } alu_rsp_t;

endpackage

### hw/rtl/rmsd_alu.sv
// ----------------------------------------------------------------------------
// rmsd_alu
// shared add/subtract unit, carry out doubles as unsigned a >= b on subtract
// ----------------------------------------------------------------------------
module rmsd_alu import rmsd_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] full;
  logic [ALU_W-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

  assign rsp.res   = full[ALU_W-1:0];
  assign rsp.carry = full[ALU_W];

endmodule

### hw/rtl/running_mean_stddev.sv
// ----------------------------------------------------------------------------
// running_mean_stddev
// online mean and sample standard deviation accumulator (welford update)
// ----------------------------------------------------------------------------
// input channel: in_tuser is the operation (add sample or report), in_tdata
// the signed 48-bit sample with 16 fraction bits. every item gives exactly
// one result item with count, mean, deviation (out_tdata) and the deviation
// valid flag (out_tuser).
// one item is worked on at a time; in_tready is high only while idle.
// an add runs two setup steps, a 48-step restoring division of the
// difference by the count, the mean and error updates, a 48-step shift-add
// multiply and the sum update, all on one shared 66-bit adder.
// a report with two or more samples runs a 64-step division of the
// deviation sum by count - 1 and a 32-step square root on the same
// adder; a report with fewer samples goes straight to its result.
// in_tready rises again as a result is loaded into the output register.
// results wait in an output register; the next item is accepted while a
// result is still waiting, and the sequencer holds its last step until the
// output register is free when the receiver stalls.
// reset (synchronous, active low) clears count, mean and deviation sum and
// drops out_tvalid.
// ----------------------------------------------------------------------------
module running_mean_stddev import rmsd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // sample_value
  input  logic         in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // sample_count, running_mean, std_deviation, zero pad
  output logic         out_tuser   // std_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIFF = 4'd1;
  localparam logic [3:0] S_ABS  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_MEAN = 4'd4;
  localparam logic [3:0] S_EMAG = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ACC  = 4'd7;
  localparam logic [3:0] S_RDIV = 4'd8;
  localparam logic [3:0] S_SQRT = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0]        state_r;
  logic [STEP_W-1:0] step_r;
  logic [31:0]       count_r;
  logic [47:0]       mean_r;
  logic [63:0]       sum_r;
  logic [47:0]       x_r;
  logic [48:0]       d_r;
  logic              dneg_r;
  logic [63:0]       qs_r;
  logic [33:0]       rem_r;
  logic [31:0]       div_r;
  logic [47:0]       emag_r;
  logic [63:0]       acc_r;
  logic              sat_r;
  logic [31:0]       root_r;
  logic              rpt_r;

  logic              out_tvalid_r;
  logic [31:0]       out_count_r;
  logic [47:0]       out_mean_r;
  logic [46:0]       out_std_r;
  logic              out_vld_r;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              last_step;
  logic              in_acc;
  logic [31:0]       count_inc;
  logic [63:0]       prod;
  logic [33:0]       sq_trial;

  rmsd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign last_step  = (step_r == {{(STEP_W-1){1'b0}}, 1'b1});
  assign count_inc  = (count_r == 32'hFFFF_FFFF) ? count_r : count_r + 32'd1;
  assign prod       = sat_r ? 64'hFFFF_FFFF_FFFF_FFFF : acc_r;
  assign sq_trial   = {rem_r[31:0], qs_r[63:62]};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_std_r, out_mean_r, out_count_r};
  assign out_tuser  = out_vld_r;

  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_DIFF: begin
        alu_req.a   = {{18{x_r[47]}}, x_r};
        alu_req.b   = {{18{mean_r[47]}}, mean_r};
        alu_req.sub = 1'b1;
      end
      S_ABS: begin
        if (d_r[48]) begin
          alu_req.b   = {{17{d_r[48]}}, d_r};
          alu_req.sub = 1'b1;
        end else begin
          alu_req.a = {17'd0, d_r};
        end
      end
      S_DIV, S_RDIV: begin
        alu_req.a   = {33'd0, rem_r[31:0], qs_r[63]};
        alu_req.b   = {34'd0, div_r};
        alu_req.sub = 1'b1;
      end
      S_MEAN: begin
        alu_req.a   = {{18{mean_r[47]}}, mean_r};
        alu_req.b   = {18'd0, qs_r[47:0]};
        alu_req.sub = dneg_r;
      end
      S_EMAG: begin
        alu_req.a   = {18'd0, d_r[47:0]};
        alu_req.b   = {18'd0, qs_r[47:0]};
        alu_req.sub = 1'b1;
      end
      S_MUL: begin
        alu_req.a = {1'b0, acc_r, 1'b0};
        alu_req.b = d_r[47] ? {18'd0, emag_r} : '0;
      end
      S_ACC: begin
        alu_req.a = {2'd0, sum_r};
        alu_req.b = {2'd0, prod};
      end
      S_SQRT: begin
        alu_req.a   = {32'd0, sq_trial};
        alu_req.b   = {32'd0, root_r, 2'b01};
        alu_req.sub = 1'b1;
      end
      default: alu_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      mean_r       <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != S_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rem_r <= '0;
            if (in_tuser == OP_ADD) begin
              count_r <= count_inc;
              div_r   <= count_inc;
              x_r     <= in_tdata;
              rpt_r   <= 1'b0;
              state_r <= S_DIFF;
            end else if (count_r >= 32'd2) begin
              div_r   <= count_r - 32'd1;
              qs_r    <= sum_r;
              step_r  <= DIV_RPT_STEPS;
              rpt_r   <= 1'b1;
              state_r <= S_RDIV;
            end else begin
              rpt_r   <= 1'b0;
              state_r <= S_DONE;
            end
          end
        end
        S_DIFF: begin
          d_r     <= alu_rsp.res[48:0];
          dneg_r  <= alu_rsp.res[48];
          state_r <= S_ABS;
        end
        S_ABS: begin
          d_r     <= {1'b0, alu_rsp.res[47:0]};
          qs_r    <= {alu_rsp.res[47:0], 16'd0};
          rem_r   <= '0;
          step_r  <= DIV_ADD_STEPS;
          state_r <= S_DIV;
        end
        S_DIV, S_RDIV: begin
          qs_r   <= {qs_r[62:0], alu_rsp.carry};
          rem_r  <= {2'd0, alu_rsp.carry ? alu_rsp.res[31:0] : {rem_r[30:0], qs_r[63]}};
          step_r <= step_r - {{(STEP_W-1){1'b0}}, 1'b1};
          if (last_step) begin
            if (state_r == S_DIV) begin
              state_r <= S_MEAN;
            end else begin
              rem_r   <= '0;
              step_r  <= SQRT_STEPS;
              root_r  <= '0;
              state_r <= S_SQRT;
            end
          end
        end
        S_MEAN: begin
          mean_r  <= alu_rsp.res[47:0];
          state_r <= S_EMAG;
        end
        S_EMAG: begin
          emag_r  <= alu_rsp.res[47:0];
          acc_r   <= '0;
          sat_r   <= 1'b0;
          step_r  <= MUL_STEPS;
          state_r <= S_MUL;
        end
        S_MUL: begin
          acc_r  <= alu_rsp.res[63:0];
          sat_r  <= sat_r | alu_rsp.res[65] | alu_rsp.res[64];
          d_r    <= {d_r[47:0], 1'b0};
          step_r <= step_r - {{(STEP_W-1){1'b0}}, 1'b1};
          if (last_step) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          sum_r   <= alu_rsp.res[64] ? 64'hFFFF_FFFF_FFFF_FFFF : alu_rsp.res[63:0];
          state_r <= S_DONE;
        end
        S_SQRT: begin
          qs_r   <= {qs_r[61:0], 2'b00};
          rem_r  <= alu_rsp.carry ? alu_rsp.res[33:0] : sq_trial;
          root_r <= {root_r[30:0], alu_rsp.carry};
          step_r <= step_r - {{(STEP_W-1){1'b0}}, 1'b1};
          if (last_step) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_count_r  <= count_r;
            out_mean_r   <= mean_r;
            out_std_r    <= rpt_r ? {15'd0, root_r} : '0;
            out_vld_r    <= rpt_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // the count only ever grows, or holds between adds and at its ceiling
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> count_r >= $past(count_r))
    else $error("sample count decreased");

  // the saturating deviation sum never shrinks
  a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> sum_r >= $past(sum_r))
    else $error("deviation sum decreased");

  // a 48-bit dividend leaves the upper quotient bits clear
  a_quot_width: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MEAN |-> qs_r[63:48] == 16'd0)
    else $error("mean step quotient overflows 48 bits");

  // the mean step never exceeds the difference magnitude
  a_emag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMAG |-> alu_rsp.carry)
    else $error("mean step larger than difference");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the running mean and standard deviation block
// ----------------------------------------------------------------------------
// a short table of directed items (empty and single-sample reports, zero,
// one-lsb and unit samples, ignored report data, extreme samples) brackets
// about 1800 random adds and reports. every accepted item goes through a
// local welford model; its expected result, or the row's own for known rows,
// is queued and compared field by field with the result stream. sender gaps
// and receiver stalls change by phase, and one long receiver hold-off fills
// the block and stalls its input. extreme samples saturate the deviation sum
// for good, so those rows run last.
// ----------------------------------------------------------------------------
module tb import rmsd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_ITEMS = 1780;
  localparam int PHASE_ITEMS  = 445;
  localparam int DRAIN_CYCLES = 150;
  localparam int HEAD_ROWS    = 14;
  localparam int TABLE_ROWS   = 23;

  typedef struct packed {
    logic [31:0] count;
    logic [47:0] mean;
    logic [46:0] stdev;
    logic        valid;
  } moments_t;

  typedef struct packed {
    logic        op;
    logic [47:0] smp;
    logic        known;
    moments_t    want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;   // sample_value
  logic         in_tuser = 1'b0; // operation
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // sample_count, running_mean, std_deviation, zero pad
  logic         out_tuser;       // std_valid

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatch_count = 0;

  logic [31:0]        acc_count = '0;
  logic signed [47:0] acc_mean = '0;
  logic [63:0]        acc_sqsum = '0;

  moments_t moments_due[$];

  running_mean_stddev u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'd0, r | (32'd1 << b)};
      if (t * t <= v) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  function automatic moments_t welford_update(input logic op, input logic [47:0] smp);
    logic signed [48:0] diff;
    logic signed [48:0] nmean;
    logic [48:0]        dmag;
    logic [48:0]        qmag;
    logic [48:0]        emag;
    logic [127:0]       prod;
    logic [64:0]        total;
    moments_t           r;
    r = '0;
    if (op == OP_ADD) begin
      if (acc_count != 32'hFFFF_FFFF) acc_count = acc_count + 32'd1;
      diff = $signed(smp) - acc_mean;
      dmag = diff[48] ? 49'(-diff) : 49'(diff);
      qmag = dmag / {17'd0, acc_count};
      emag = dmag - qmag;
      nmean = diff[48] ? acc_mean - $signed(qmag) : acc_mean + $signed(qmag);
      acc_mean = nmean[47:0];
      prod = 128'(emag) * 128'(dmag);
      if (prod[127:64] != '0) prod = {64'd0, {64{1'b1}}};
      total = {1'b0, acc_sqsum} + {1'b0, prod[63:0]};
      acc_sqsum = total[64] ? {64{1'b1}} : total[63:0];
    end else if (acc_count >= 32'd2) begin
      r.stdev = 47'(floor_root(acc_sqsum / (64'(acc_count) - 64'd1)));
      r.valid = 1'b1;
    end
    r.count = acc_count;
    r.mean = acc_mean;
    return r;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    logic [47:0] mag;
    r = '0;
    if ($urandom_range(99) < 80) begin
      r.op = OP_ADD;
      case ($urandom_range(9))
        0: mag = 48'($urandom_range(255));
        1, 2, 3, 4, 5, 6: mag = 48'($urandom_range(32'h0010_0000));
        default: mag = 48'($urandom_range(32'h0100_0000));
      endcase
      r.smp = $urandom_range(1) ? -mag : mag;
    end else begin
      r.op = OP_REPORT;
      r.smp = 48'({$urandom(), $urandom()});
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic offer_item(input logic op, input logic [47:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= smp;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic apply_row(input stim_row_t row);
    moments_t m;
    offer_item(row.op, row.smp);
    m = welford_update(row.op, row.smp);
    if (row.known) m = row.want;
    moments_due.insert(moments_due.size(), m);
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    moments_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (moments_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], '0);
      end else begin
        want = moments_due.pop_front();
        if (out_tdata[31:0] != want.count)
          report_mismatch("sample_count", 64'(out_tdata[31:0]), 64'(want.count));
        if (out_tdata[79:32] != want.mean)
          report_mismatch("running_mean", 64'(out_tdata[79:32]), 64'(want.mean));
        if (out_tdata[126:80] != want.stdev)
          report_mismatch("std_deviation", 64'(out_tdata[126:80]), 64'(want.stdev));
        if (out_tuser != want.valid)
          report_mismatch("std_valid", 64'(out_tuser), 64'(want.valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [0:TABLE_ROWS-1];
    rows[0]  = '{OP_REPORT, 48'h0000_0000_0000, 1'b1, '{32'd0, 48'd0, 47'd0, 1'b0}};
    rows[1]  = '{OP_REPORT, 48'hFFFF_FFFF_FFFF, 1'b1, '{32'd0, 48'd0, 47'd0, 1'b0}};
    rows[2]  = '{OP_ADD,    48'h0000_0000_0000, 1'b1, '{32'd1, 48'd0, 47'd0, 1'b0}};
    rows[3]  = '{OP_REPORT, 48'h0000_0000_0000, 1'b1, '{32'd1, 48'd0, 47'd0, 1'b0}};
    rows[4]  = '{OP_ADD,    48'h0000_0000_0000, 1'b1, '{32'd2, 48'd0, 47'd0, 1'b0}};
    rows[5]  = '{OP_REPORT, 48'h0000_0000_0000, 1'b1, '{32'd2, 48'd0, 47'd0, 1'b1}};
    rows[6]  = '{OP_ADD,    48'h0000_0001_0000, 1'b0, '0};
    rows[7]  = '{OP_ADD,    48'hFFFF_FFFF_0000, 1'b0, '0};
    rows[8]  = '{OP_ADD,    48'h0000_0000_0001, 1'b0, '0};
    rows[9]  = '{OP_ADD,    48'hFFFF_FFFF_FFFF, 1'b0, '0};
    rows[10] = '{OP_REPORT, 48'h8000_0000_0000, 1'b0, '0};
    rows[11] = '{OP_ADD,    48'h0000_00FF_FFFF, 1'b0, '0};
    rows[12] = '{OP_ADD,    48'hFFFF_FF00_0000, 1'b0, '0};
    rows[13] = '{OP_REPORT, 48'h5555_AAAA_5555, 1'b0, '0};
    // extreme samples: deviation sum saturates and stays there
    rows[14] = '{OP_ADD,    48'h7FFF_FFFF_FFFF, 1'b0, '0};
    rows[15] = '{OP_REPORT, 48'h0000_0000_0000, 1'b0, '0};
    rows[16] = '{OP_ADD,    48'h8000_0000_0000, 1'b0, '0};
    rows[17] = '{OP_REPORT, 48'h0000_0000_0000, 1'b0, '0};
    rows[18] = '{OP_ADD,    48'h8000_0000_0000, 1'b0, '0};
    rows[19] = '{OP_ADD,    48'h7FFF_FFFF_FFFF, 1'b0, '0};
    rows[20] = '{OP_REPORT, 48'h0000_0000_0000, 1'b0, '0};
    rows[21] = '{OP_ADD,    48'h0000_0000_0000, 1'b0, '0};
    rows[22] = '{OP_REPORT, 48'h0000_0000_0000, 1'b0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < HEAD_ROWS; i++) apply_row(rows[i]);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_ITEMS == 0) begin
        case (k / PHASE_ITEMS)
          0: begin
            src_idle_pct = 0;
            sink_stall_pct <= 0;
          end
          1: begin
            src_idle_pct = 51;
            sink_stall_pct <= 0;
          end
          2: begin
            src_idle_pct = 0;
            sink_stall_pct <= 51;
          end
          default: begin
            src_idle_pct = 8;
            sink_stall_pct <= 8;
          end
        endcase
      end
      if (k == 100) hold_req <= 1'b1;
      apply_row(random_row());
    end

    for (int i = HEAD_ROWS; i < TABLE_ROWS; i++) apply_row(rows[i]);
    in_tvalid <= 1'b0;

    while (moments_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rmsd_pkg.sv
hw/rtl/rmsd_alu.sv
hw/rtl/running_mean_stddev.sv
bench/tb.sv
